### hdl/smdf_pkg.sv
package smdf_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 2;
    localparam int SUM_W  = 35;
    localparam int DSUM_W = 34;
    localparam int MEAN_W = 17;
    localparam int FRAC_W = 8;
    localparam int ADD_W  = 10;
    // integer bits of the mean; sum >> INT_W compared against count gives saturation
    localparam int INT_W  = MEAN_W - FRAC_W;
    localparam int SHR_W  = SUM_W - INT_W;
    localparam int STEP_W = $clog2(MEAN_W);

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic [4:0] {
        S_RUN  = 5'b00001,
        S_LAST = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic div_step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic last_pix;
        logic out_free;
    } t_stat;

endpackage

### hdl/sum_modulus_difference_focus_core.sv
// Sum-modulus-difference focus measure. Grey pixels stream in raster order,
// one beat per pixel, at one pixel per clock inside a frame. Each pixel adds
// |p - left| + |p - above| to a saturating 35-bit frame sum; the missing
// first-column and first-row terms are mirrored (reflect-101) by counting the
// second column's and second row's terms twice. The previous row lives in an
// 8-bit x MAX_WIDTH line store; it is never cleared, since every entry is
// written in row 0 before row 1 reads it. On the frame's last pixel the input
// stalls while the last terms are folded into the sum and the sum is
// snapshotted, and a restoring divider forms the 17-bit quotient
// floor(sum * 256 / (width * height)); then the result beat is loaded.
// The stall runs longer only if the previous frame's result has not yet been
// taken. A result beat carries diff_sum (saturated at 2^34-1) and mean_q8
// (8 fraction bits, truncated, saturated at 2^17-1). frame_width and
// frame_height are clamped to [2, MAX] and should be written between frames.
module sum_modulus_difference_focus_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register writes
    input  logic                          i_cfg_we,
    input  logic [smdf_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [smdf_pkg::CFG_W-1:0]    i_cfg_data,
    // pixel beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [smdf_pkg::PIX_W-1:0]    i_pixel,
    // result beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [smdf_pkg::DSUM_W-1:0]   o_diff_sum,
    output logic [smdf_pkg::MEAN_W-1:0]   o_mean_q8
);

    smdf_pkg::t_cmd  cmd;
    smdf_pkg::t_stat stat;

    // sequencing: pixel intake, end-of-frame divide, result hand-off
    smdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // counters, line store, accumulator, divider, output register
    smdf_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (i_pixel),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_diff_sum  (o_diff_sum),
        .o_mean_q8   (o_mean_q8)
    );

endmodule

### hdl/smdf_ctrl.sv
module smdf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  smdf_pkg::t_stat      i_stat,
    output smdf_pkg::t_cmd       o_cmd
);

    smdf_pkg::t_state                r_state, n_state;
    logic [smdf_pkg::STEP_W-1:0]     r_step, n_step;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_in_stall   = (r_state != smdf_pkg::S_RUN);
        unique case (r_state)
            smdf_pkg::S_RUN: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.last_pix) begin
                    n_state = smdf_pkg::S_LAST;
                end
            end
            smdf_pkg::S_LAST: begin
                // last pixel's terms land in the sum this cycle
                n_state = smdf_pkg::S_LOAD;
            end
            smdf_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = smdf_pkg::S_DIV;
            end
            smdf_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == smdf_pkg::STEP_W'(smdf_pkg::MEAN_W - 1)) begin
                    n_state = smdf_pkg::S_DONE;
                end
            end
            smdf_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = smdf_pkg::S_RUN;
                end
            end
            default: begin
                n_state = smdf_pkg::S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smdf_pkg::S_RUN;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### hdl/smdf_dpath.sv
module smdf_dpath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [smdf_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [smdf_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [smdf_pkg::PIX_W-1:0]    i_pixel,
    input  logic                          i_out_stall,
    input  smdf_pkg::t_cmd                i_cmd,
    output smdf_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output logic [smdf_pkg::DSUM_W-1:0]   o_diff_sum,
    output logic [smdf_pkg::MEAN_W-1:0]   o_mean_q8
);

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int RB    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = (WW > smdf_pkg::CFG_W) ? WW : smdf_pkg::CFG_W;
    localparam int YW    = (HW > smdf_pkg::CFG_W) ? HW : smdf_pkg::CFG_W;
    localparam int CNT_W = WW + HW;
    localparam int CMP_W = (CNT_W > smdf_pkg::SHR_W) ? CNT_W : smdf_pkg::SHR_W;
    localparam int PW    = smdf_pkg::PIX_W;
    localparam int SW    = smdf_pkg::SUM_W;

    // configuration
    logic [smdf_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [XW-1:0]              fw_x;
    logic [YW-1:0]              fh_x;
    logic [WW-1:0]              w_use;
    logic [HW-1:0]              h_use;

    // raster position
    logic [CB-1:0]              r_col;
    logic [RB-1:0]              r_row;
    logic                       col_end, row_end;

    // line store and pixel stage
    logic [PW-1:0]              r_row_store [MAX_WIDTH];
    logic [PW-1:0]              r_left;
    logic [PW-1:0]              r_s_pix, r_s_left, r_s_above;
    logic                       r_s_col0, r_s_col1, r_s_row0, r_s_row1;
    logic                       r_s_v;

    // accumulate stage
    logic [PW-1:0]                  dh, dv;
    logic [smdf_pkg::ADD_W-1:0]     h_term, v_term, add_v;
    logic [SW:0]                    sum_ext;
    logic [SW-1:0]                  r_sum;

    // divider
    logic [CNT_W-1:0]               r_count;
    logic [CNT_W-1:0]               r_rem;
    logic [CNT_W:0]                 trial;
    logic                           trial_ge;
    logic [smdf_pkg::MEAN_W-1:0]    r_nbits, r_quo;
    logic                           r_sat;
    logic [smdf_pkg::DSUM_W-1:0]    r_dsum;
    logic [smdf_pkg::SHR_W-1:0]     sum_hi;

    logic                           r_out_valid;
    logic [smdf_pkg::DSUM_W-1:0]    r_out_dsum;
    logic [smdf_pkg::MEAN_W-1:0]    r_out_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= smdf_pkg::FRAME_WIDTH_RST;
            r_cfg_h <= smdf_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == smdf_pkg::REG_FRAME_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end else if (i_cfg_index == smdf_pkg::REG_FRAME_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    // clamp to [2, MAX]
    always_comb begin
        fw_x = XW'(r_cfg_w);
        fh_x = YW'(r_cfg_h);
        if (fw_x < XW'(2)) begin
            w_use = WW'(2);
        end else if (fw_x > XW'(MAX_WIDTH)) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = WW'(fw_x);
        end
        if (fh_x < YW'(2)) begin
            h_use = HW'(2);
        end else if (fh_x > YW'(MAX_HEIGHT)) begin
            h_use = HW'(MAX_HEIGHT);
        end else begin
            h_use = HW'(fh_x);
        end
    end

    assign col_end = ((WW+1)'(r_col) + (WW+1)'(1)) >= (WW+1)'(w_use);
    assign row_end = ((HW+1)'(r_row) + (HW+1)'(1)) >= (HW+1)'(h_use);

    assign o_stat.last_pix = col_end && row_end;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
            r_s_v  <= 1'b0;
        end else begin
            r_s_v <= i_cmd.accept;
            if (i_cmd.accept) begin
                r_left <= i_pixel;
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // line store: read-before-write at the current column
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_row_store[r_col] <= i_pixel;
            r_s_above          <= r_row_store[r_col];
            r_s_pix            <= i_pixel;
            r_s_left           <= r_left;
            r_s_col0           <= (r_col == '0);
            r_s_col1           <= (r_col == CB'(1));
            r_s_row0           <= (r_row == '0);
            r_s_row1           <= (r_row == RB'(1));
        end
    end

    // reflect-101: second column / second row terms count twice
    always_comb begin
        dh = (r_s_pix > r_s_left)  ? r_s_pix - r_s_left  : r_s_left - r_s_pix;
        dv = (r_s_pix > r_s_above) ? r_s_pix - r_s_above : r_s_above - r_s_pix;
        if (r_s_col0) begin
            h_term = '0;
        end else if (r_s_col1) begin
            h_term = {1'b0, dh, 1'b0};
        end else begin
            h_term = smdf_pkg::ADD_W'(dh);
        end
        if (r_s_row0) begin
            v_term = '0;
        end else if (r_s_row1) begin
            v_term = {1'b0, dv, 1'b0};
        end else begin
            v_term = smdf_pkg::ADD_W'(dv);
        end
        add_v   = h_term + v_term;
        sum_ext = {1'b0, r_sum} + (SW+1)'(add_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.load) begin
            r_sum <= '0;
        end else if (r_s_v) begin
            r_sum <= sum_ext[SW] ? '1 : sum_ext[SW-1:0];
        end
    end

    // pixel count, registered straight off the multiplier
    always_ff @(posedge i_clk) begin
        r_count <= CNT_W'(w_use) * CNT_W'(h_use);
    end

    assign sum_hi   = r_sum[SW-1 -: smdf_pkg::SHR_W];
    assign trial    = {r_rem, r_nbits[smdf_pkg::MEAN_W-1]};
    assign trial_ge = trial >= (CNT_W+1)'(r_count);

    // restoring divide, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dsum  <= r_sum[SW-1] ? '1 : r_sum[smdf_pkg::DSUM_W-1:0];
            r_sat   <= CMP_W'(sum_hi) >= CMP_W'(r_count);
            r_rem   <= CNT_W'(sum_hi);
            r_nbits <= {r_sum[smdf_pkg::INT_W-1:0], smdf_pkg::FRAC_W'(0)};
            r_quo   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= trial_ge ? CNT_W'(trial - (CNT_W+1)'(r_count)) : CNT_W'(trial);
            r_nbits <= {r_nbits[smdf_pkg::MEAN_W-2:0], 1'b0};
            r_quo   <= {r_quo[smdf_pkg::MEAN_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_dsum <= r_dsum;
            r_out_mean <= r_sat ? '1 : r_quo;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_diff_sum  = r_out_dsum;
    assign o_mean_q8   = r_out_mean;

endmodule

### hdl/smdf_checker.sv
module smdf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [smdf_pkg::DSUM_W-1:0]   o_diff_sum,
    input  logic [smdf_pkg::MEAN_W-1:0]   o_mean_q8
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_diff_sum) && $stable(o_mean_q8))
        else $error("result beat changed while stalled");

    // a result only follows the end-of-frame divide, during which intake stalls
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without end-of-frame stall");

    // zero sum means zero mean
    a_zero_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_diff_sum == '0) |-> (o_mean_q8 == '0))
        else $error("nonzero mean for zero sum");

    // nothing pending right out of reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sum_modulus_difference_focus_core smdf_checker u_smdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_diff_sum  (o_diff_sum),
    .o_mean_q8   (o_mean_q8)
);

### bench/sum_modulus_difference_focus_core_test.sv
// Bench for the sum-modulus-difference focus core.
//
// Pixels go in through a queue that the stimulus block fills. A clocked
// driver presents one beat at a time and feeds every accepted pixel to a
// local model of the block. That model keeps its own copy of the line store,
// the counters and the frame sum, and on a frame's last pixel it queues the
// expected result beat. A clocked monitor takes result beats and compares
// each field with the oldest queued frame result.
//
// Both sides drop their handshake about a quarter of the time. One run of
// frames goes through with no gaps at all. At least once the driver holds
// off after a frame's last pixel until its result has been taken.
//
// Registers are only written while the block is idle. That means after reset
// and between groups of frames, once the pixel queue is drained and every
// result is in.
module sum_modulus_difference_focus_core_test;

    localparam int          HALF_PERIOD = 10;
    localparam int          RESET_CYCLES = 6;
    localparam int          LINE_MAX = 4096;     // block default MAX_WIDTH
    localparam int          ROWS_MAX = 4096;     // block default MAX_HEIGHT
    localparam int          IDLE_PCT = 24;
    localparam int          SETTLE_CYCLES = 30;  // margin for the end-of-frame stall
    localparam int          RAND_ITEMS = 1200;
    localparam longint      RUN_LIMIT = 64'd20 * 64'd600_000;

    // register indexes the block does not decode
    localparam logic [smdf_pkg::IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [smdf_pkg::IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam longint unsigned SUM_LIMIT  = (64'd1 << smdf_pkg::SUM_W) - 64'd1;
    localparam longint unsigned DSUM_LIMIT = (64'd1 << smdf_pkg::DSUM_W) - 64'd1;
    localparam longint unsigned MEAN_LIMIT = (64'd1 << smdf_pkg::MEAN_W) - 64'd1;

    typedef enum int {
        PIX_NOISE,
        PIX_RAIL,
        PIX_DRIFT,
        PIX_FLAT
    } t_pix_style;

    typedef struct packed {
        logic [smdf_pkg::DSUM_W-1:0] diff_sum;
        logic [smdf_pkg::MEAN_W-1:0] mean_q8;
    } t_frame_result;

    // ---------------------------------------------------------------- DUT
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [smdf_pkg::IDX_W-1:0]     i_cfg_index = '0;
    logic [smdf_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic [smdf_pkg::PIX_W-1:0]     i_pixel = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [smdf_pkg::DSUM_W-1:0]    o_diff_sum;
    logic [smdf_pkg::MEAN_W-1:0]    o_mean_q8;

    sum_modulus_difference_focus_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_diff_sum  (o_diff_sum),
        .o_mean_q8   (o_mean_q8)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // ------------------------------------------------------ bench state
    logic [smdf_pkg::PIX_W-1:0] pix_q[$];        // pixels waiting for the driver
    t_frame_result        frame_results_q[$];    // predicted result beats
    int unsigned          results_owed = 0;      // driver side, nonblocking
    int unsigned          results_taken = 0;     // monitor side, nonblocking
    logic                 draining = 1'b0;       // driver holds until results are in
    int unsigned          drains = 0;
    logic                 steady = 1'b0;         // no gaps on either side
    int unsigned          mismatches = 0;
    int unsigned          pixels_taken = 0;
    int unsigned          frames_checked = 0;
    int unsigned          cur_w = 2;             // clamped size the next frames use
    int unsigned          cur_h = 2;
    int unsigned          widest = 0;
    int unsigned          tallest = 0;

    // -------------------------------------------------- model of the block
    logic [smdf_pkg::CFG_W-1:0] mdl_width = smdf_pkg::FRAME_WIDTH_RST;
    logic [smdf_pkg::CFG_W-1:0] mdl_height = smdf_pkg::FRAME_HEIGHT_RST;
    logic [smdf_pkg::PIX_W-1:0] line_mdl[LINE_MAX];
    logic [smdf_pkg::PIX_W-1:0] mdl_left = '0;
    int unsigned          mdl_col = 0;
    int unsigned          mdl_row = 0;
    longint unsigned      mdl_sum = 0;

    initial begin
        // entries only matter once row 0 has written them
        for (int i = 0; i < LINE_MAX; i++) line_mdl[i] = '0;
    end

    // out-of-range sizes fall back to [2, max]
    function automatic int unsigned clamp_dim(input logic [smdf_pkg::CFG_W-1:0] v,
                                              input int unsigned hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic int unsigned absdiff(input logic [smdf_pkg::PIX_W-1:0] a,
                                            input logic [smdf_pkg::PIX_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    // One pixel through the model; returns 1 when the frame ends and fills
    // in the result beat.
    function automatic bit smd_step(input logic [smdf_pkg::PIX_W-1:0] p,
                                    output logic [smdf_pkg::DSUM_W-1:0] ds,
                                    output logic [smdf_pkg::MEAN_W-1:0] mq);
        int unsigned     w;
        int unsigned     h;
        int unsigned     col;
        int unsigned     row;
        int unsigned     d;
        logic [smdf_pkg::PIX_W-1:0] up;
        longint unsigned add;
        longint unsigned cnt;
        longint unsigned mean;
        w = clamp_dim(mdl_width, LINE_MAX);
        h = clamp_dim(mdl_height, ROWS_MAX);
        col = mdl_col;
        row = mdl_row;
        add = 0;
        ds = '0;
        mq = '0;
        // reflect-101: column 1 and row 1 terms stand in for column 0 / row 0
        if (col != 0) begin
            d = absdiff(p, mdl_left);
            add += (col == 1) ? 2 * d : d;
        end
        if (row != 0) begin
            up = (col < LINE_MAX) ? line_mdl[col] : '0;
            d = absdiff(p, up);
            add += (row == 1) ? 2 * d : d;
        end
        if (col < LINE_MAX) line_mdl[col] = p;
        mdl_left = p;
        mdl_sum += add;
        if (mdl_sum > SUM_LIMIT) mdl_sum = SUM_LIMIT;

        if (col + 1 >= w) begin
            mdl_col = 0;
            if (row + 1 >= h) begin
                cnt = longint'(w) * longint'(h);
                mean = (mdl_sum << smdf_pkg::FRAC_W) / cnt;
                ds = smdf_pkg::DSUM_W'((mdl_sum > DSUM_LIMIT) ? DSUM_LIMIT : mdl_sum);
                mq = smdf_pkg::MEAN_W'((mean > MEAN_LIMIT) ? MEAN_LIMIT : mean);
                mdl_sum = 0;
                mdl_row = 0;
                return 1'b1;
            end
            mdl_row = row + 1;
        end else begin
            mdl_col = col + 1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------- driver
    // Accepted pixel -> model. A new beat is only picked once the current
    // one is gone, so a stalled beat never changes.
    always @(posedge i_clk) begin : pixel_driver
        logic [smdf_pkg::DSUM_W-1:0] ds;
        logic [smdf_pkg::MEAN_W-1:0] mq;
        logic              start_drain;
        logic              hold;
        start_drain = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pixels_taken++;
                if (smd_step(i_pixel, ds, mq)) begin
                    frame_results_q.push_back('{diff_sum: ds, mean_q8: mq});
                    results_owed <= results_owed + 1;
                    // first frame end always, then now and then outside the gapless run
                    if (drains == 0 || (!steady && $urandom_range(7) == 0)) begin
                        start_drain = 1'b1;
                        drains++;
                    end
                end
            end
            hold = start_drain || (draining && results_owed != results_taken);
            draining <= hold;
            if (!i_in_valid || !o_in_stall) begin
                if (!hold && pix_q.size() != 0 &&
                        (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_pixel <= pix_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------ monitor
    always @(posedge i_clk) begin : result_monitor
        t_frame_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frame_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %0d / %0d",
                             $time, o_diff_sum, o_mean_q8);
                end else begin
                    want = frame_results_q.pop_front();
                    results_taken <= results_taken + 1;
                    frames_checked++;
                    if (o_diff_sum !== want.diff_sum) begin
                        mismatches++;
                        $display("%0t: diff_sum expected %0d actual %0d",
                                 $time, want.diff_sum, o_diff_sum);
                    end
                    if (o_mean_q8 !== want.mean_q8) begin
                        mismatches++;
                        $display("%0t: mean_q8 expected %0d actual %0d",
                                 $time, want.mean_q8, o_mean_q8);
                    end
                end
            end
            i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------ stimulus side
    // Everything below runs at the falling edge for queue work and at the
    // rising edge for register writes, so nothing races the clocked blocks.

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pix_q.size() != 0 || i_in_valid || draining ||
               results_owed != results_taken);
        // margin before the caller goes on; every result is in by now
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [smdf_pkg::IDX_W-1:0] idx,
                             input logic [smdf_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            smdf_pkg::REG_FRAME_WIDTH:  mdl_width = val;
            smdf_pkg::REG_FRAME_HEIGHT: mdl_height = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Idle the block, then program the frame size; sometimes throw in a
    // write to an undecoded index.
    task automatic setup_frame(input logic [smdf_pkg::CFG_W-1:0] w_val,
                               input logic [smdf_pkg::CFG_W-1:0] h_val);
        bit spare_first;
        bit spare;
        spare = ($urandom_range(3) == 0);
        spare_first = ($urandom_range(1) == 1);
        wait_drained();
        if (spare && spare_first)
            write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                      smdf_pkg::CFG_W'($urandom));
        if ($urandom_range(1)) begin
            write_reg(smdf_pkg::REG_FRAME_WIDTH, w_val);
            write_reg(smdf_pkg::REG_FRAME_HEIGHT, h_val);
        end else begin
            write_reg(smdf_pkg::REG_FRAME_HEIGHT, h_val);
            write_reg(smdf_pkg::REG_FRAME_WIDTH, w_val);
        end
        if (spare && !spare_first)
            write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                      smdf_pkg::CFG_W'($urandom));
        end_writes();
        cur_w = clamp_dim(mdl_width, LINE_MAX);
        cur_h = clamp_dim(mdl_height, ROWS_MAX);
        if (cur_w > widest) widest = cur_w;
        if (cur_h > tallest) tallest = cur_h;
    endtask

    task automatic queue_frames(input int unsigned nframes, input t_pix_style style);
        logic [smdf_pkg::PIX_W-1:0] pix;
        logic [smdf_pkg::PIX_W-1:0] base;
        @(negedge i_clk);
        pix = smdf_pkg::PIX_W'($urandom);
        base = pix;
        for (int unsigned n = 0; n < nframes * cur_w * cur_h; n++) begin
            case (style)
                PIX_RAIL:  pix = $urandom_range(1) ? 8'hFF : 8'h00;
                PIX_DRIFT: pix = pix + smdf_pkg::PIX_W'($urandom_range(6)) - 8'd3;
                PIX_FLAT:  pix = base;
                default:   pix = smdf_pkg::PIX_W'($urandom);
            endcase
            pix_q.push_back(pix);
        end
    endtask

    initial begin : stimulus
        int unsigned rand_pixels;
        int unsigned phase;
        int unsigned nf;
        logic [smdf_pkg::CFG_W-1:0] w_val;
        logic [smdf_pkg::CFG_W-1:0] h_val;
        rand_pixels = 0;
        phase = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // -- directed frames
        // 2x2 checkerboard of full-scale steps: largest terms, doubled edges
        setup_frame(13'd2, 13'd2);
        @(negedge i_clk);
        pix_q.push_back(8'h00);
        pix_q.push_back(8'hFF);
        pix_q.push_back(8'hFF);
        pix_q.push_back(8'h00);

        // sizes below range clamp to 2x2; undecoded indexes must not
        // disturb the frame size
        setup_frame(13'd0, 13'd1);
        write_reg(REG_SPARE_2, 13'h1FFF);
        write_reg(REG_SPARE_3, 13'h1FFF);
        end_writes();
        @(negedge i_clk);
        repeat (4) pix_q.push_back(8'hFF);

        // 3x3 alternating rails
        setup_frame(13'd3, 13'd3);
        @(negedge i_clk);
        for (int i = 0; i < 9; i++) pix_q.push_back((i % 2) ? 8'hFF : 8'h00);

        // 4x2 random rails
        setup_frame(13'd4, 13'd2);
        queue_frames(1, PIX_RAIL);

        // -- random frames, mostly small so results come often
        while (rand_pixels < RAND_ITEMS) begin
            w_val = smdf_pkg::CFG_W'($urandom_range(2, 12));
            h_val = smdf_pkg::CFG_W'($urandom_range(2, 8));
            case ($urandom_range(19))
                0: w_val = smdf_pkg::CFG_W'($urandom_range(1));    // clamps up
                1: h_val = smdf_pkg::CFG_W'($urandom_range(1));
                2: begin
                    w_val = smdf_pkg::CFG_W'($urandom_range(13, 64)); // a few wide rows
                    h_val = smdf_pkg::CFG_W'($urandom_range(2, 3));
                end
                default: ;
            endcase
            // one stretch of frames with both sides running flat out
            @(negedge i_clk);
            steady = (phase >= 8 && phase < 16);
            setup_frame(w_val, h_val);
            nf = $urandom_range(1, 3);
            queue_frames(nf, t_pix_style'($urandom_range(3)));
            rand_pixels += nf * cur_w * cur_h;
            phase++;
        end
        @(negedge i_clk);
        steady = 1'b0;

        // back down to a small frame after the wide ones
        setup_frame(13'd5, 13'd3);
        queue_frames(2, PIX_NOISE);

        wait_drained();
        if (frame_results_q.size() != 0) begin
            mismatches++;
            $display("%0t: %0d result beats never arrived, expected %0d actual 0",
                     $time, frame_results_q.size(), frame_results_q.size());
        end

        $display("Covered %0d pixel beats in %0d checked frames,", pixels_taken,
                 frames_checked);
        $display("sizes up to %0d x %0d, clamped sizes, undecoded writes, %0d drains.",
                 widest, tallest, drains);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sum_modulus_difference_focus_core.f
hdl/smdf_pkg.sv
hdl/smdf_ctrl.sv
hdl/smdf_dpath.sv
hdl/sum_modulus_difference_focus_core.sv
hdl/smdf_checker.sv
bench/sum_modulus_difference_focus_core_test.sv
